### sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, controller types and the Q16.16
// saturation and clamp helpers used by the controller and the datapath.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Word widths of the Q16.16 arithmetic.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned OPND_W  = DATA_W + 1;
    localparam int unsigned PROD_W  = 2 * OPND_W;
    localparam int unsigned SUM_W   = DATA_W + 2;
    localparam int unsigned DIVD_W  = DATA_W + FRAC_W;

    // The serial divider produces one quotient bit per cycle.
    localparam int unsigned DIV_STEPS = DIVD_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;

    // Upper limit after reset is 255.0.
    localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RESET = 32'sh00FF_0000;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MSEL_P   = 2'd0,
        MSEL_I   = 2'd1,
        MSEL_D   = 2'd2,
        MSEL_INC = 2'd3
    } mul_sel_t;

    // Controller states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_MUL_P   = 11'b000_0000_0010,
        ST_MUL_I   = 11'b000_0000_0100,
        ST_MUL_D   = 11'b000_0000_1000,
        ST_MUL_INC = 11'b000_0001_0000,
        ST_ACC     = 11'b000_0010_0000,
        ST_INTEG   = 11'b000_0100_0000,
        ST_DIV     = 11'b000_1000_0000,
        ST_FIXD    = 11'b001_0000_0000,
        ST_SUM     = 11'b010_0000_0000,
        ST_DONE    = 11'b100_0000_0000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take;
        logic     clear;
        mul_sel_t mul_sel;
        logic     cap_diff;
        logic     cap_p;
        logic     cap_a;
        logic     cap_num;
        logic     cap_inc;
        logic     integ_upd;
        logic     div_load;
        logic     div_step;
        logic     fix_d;
        logic     sum;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } stat_t;

    // Result of a clamp against the limits.
    typedef struct packed {
        logic                      hit;
        logic signed [DATA_W-1:0]  val;
    } clamp_t;

    // Shift a full product right by the fraction width (towards minus
    // infinity) and saturate it to a signed word.
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [PROD_W-1:0] prod);
        logic [PROD_W-DATA_W-FRAC_W:0] top;
        top = prod[PROD_W-1:DATA_W+FRAC_W-1];
        if (top == '0 || top == '1)
            sat_q = prod[DATA_W+FRAC_W-1:FRAC_W];
        else if (prod[PROD_W-1])
            sat_q = SAT_MIN;
        else
            sat_q = SAT_MAX;
    endfunction

    // Saturate a sum of up to three words to a signed word.
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] top;
        top = v[SUM_W-1:DATA_W-1];
        if (top == '0 || top == '1)
            sat_sum = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            sat_sum = SAT_MIN;
        else
            sat_sum = SAT_MAX;
    endfunction

    // The lower limit wins, so crossed limits always give one of them.
    function automatic clamp_t clamp_lim(input logic signed [SUM_W-1:0] v,
                                         input logic signed [DATA_W-1:0] low,
                                         input logic signed [DATA_W-1:0] high);
        clamp_t r;
        logic signed [SUM_W-1:0] low_x;
        logic signed [SUM_W-1:0] high_x;
        low_x  = SUM_W'(low);
        high_x = SUM_W'(high);
        r.hit  = 1'b0;
        r.val  = v[DATA_W-1:0];
        if (v < low_x)
        begin
            r.hit = 1'b1;
            r.val = low;
        end
        else if (v > high_x)
        begin
            r.hit = 1'b1;
            r.val = high;
        end
        return r;
    endfunction

endpackage

### sv/pidc_in_if.sv
// ----------------------------------------------------------------------------
// PID controller item channel
// Valid/ready channel that carries one compute or clear word.
// ----------------------------------------------------------------------------
interface pidc_in_if
    import pidc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [DATA_W-1:0]  measurement;
    logic signed [DATA_W-1:0]  target;
    logic        [DATA_W-1:0]  elapsed;

    modport source (output valid, kind, measurement, target, elapsed, input ready);
    modport sink   (input valid, kind, measurement, target, elapsed, output ready);
endinterface

### sv/pidc_out_if.sv
// ----------------------------------------------------------------------------
// PID controller result channel
// Valid/ready channel that carries one controller output word.
// ----------------------------------------------------------------------------
interface pidc_out_if
    import pidc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  drive;
    logic                      clamped;
    logic                      zero_elapsed;

    modport source (output valid, drive, clamped, zero_elapsed, input ready);
    modport sink   (input valid, drive, clamped, zero_elapsed, output ready);
endinterface

### sv/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// One-hot state machine that walks the datapath through the multiplies,
// the integral update, the serial divide and the output sum, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    input  logic  item_kind,
    output logic  item_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   item_fire;
    logic   out_free;

    // A word is taken only between items; the output register is separate.
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                    state_next = item_kind ? ST_DONE : ST_MUL_P;
            end
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_MUL_INC;
            ST_MUL_INC: state_next = ST_ACC;
            ST_ACC:     state_next = ST_INTEG;
            ST_INTEG:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = ST_FIXD;
            end
            ST_FIXD:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath commands decoded from the state.
    always_comb
    begin
        cmd           = '0;
        cmd.take      = item_fire && !item_kind;
        cmd.clear     = item_fire && item_kind;
        cmd.cap_diff  = (state_reg == ST_MUL_P);
        cmd.cap_p     = (state_reg == ST_MUL_I);
        cmd.cap_a     = (state_reg == ST_MUL_D);
        cmd.cap_num   = (state_reg == ST_MUL_INC);
        cmd.cap_inc   = (state_reg == ST_ACC);
        cmd.div_load  = (state_reg == ST_ACC);
        cmd.integ_upd = (state_reg == ST_INTEG);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.fix_d     = (state_reg == ST_FIXD);
        cmd.sum       = (state_reg == ST_SUM);
        cmd.out_load  = (state_reg == ST_DONE) && out_free;
        unique case (state_reg)
            ST_MUL_I:   cmd.mul_sel = MSEL_I;
            ST_MUL_D:   cmd.mul_sel = MSEL_D;
            ST_MUL_INC: cmd.mul_sel = MSEL_INC;
            default:    cmd.mul_sel = MSEL_P;
        endcase
    end

    // Output valid is set on load and cleared once the word is taken.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // A compute word always starts with the proportional multiply.
    a_take_seq: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && !item_kind |=> state_reg == ST_MUL_P)
        else $error("compute word did not start the multiply sequence");

    // A finished word never overwrites one still waiting at the output.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid_reg || result_ready))
        else $error("output register overwritten");

    // The divider runs until the datapath reports its last step.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !stat.div_last |=> state_reg == ST_DIV)
        else $error("divider left early");

endmodule

### sv/pidc_dp.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, the shared 33x33 multiplier, the restoring
// divider for the derivative term, integral and error state, and the
// output register.
// ----------------------------------------------------------------------------
module pidc_dp
    import pidc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [DATA_W-1:0]         cfg_data,
    input  logic signed [DATA_W-1:0]  measurement,
    input  logic signed [DATA_W-1:0]  target,
    input  logic        [DATA_W-1:0]  elapsed,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    output logic signed [DATA_W-1:0]  drive,
    output logic                      clamped,
    output logic                      zero_elapsed
);

    // Configuration.
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic signed [DATA_W-1:0] limit_low_reg;
    logic signed [DATA_W-1:0] limit_high_reg;

    // Controller state kept between items.
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] integral_next;
    logic signed [DATA_W-1:0] prev_reg;

    // Per-item working registers.
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] err_next;
    logic        [DATA_W-1:0] dt_reg;
    logic                     zero_reg;
    logic signed [DATA_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] p_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] num_reg;
    logic signed [DATA_W-1:0] inc_reg;
    logic signed [DATA_W-1:0] d_reg;
    logic signed [DATA_W-1:0] d_next;

    // Shared multiplier.
    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;

    // Serial divider.
    logic        [DATA_W-1:0] div_rem_reg;
    logic        [DIVD_W-1:0] div_quo_reg;
    logic                     div_neg_reg;
    logic        [DIV_CNT_W-1:0] div_cnt_reg;
    logic        [DATA_W-1:0] num_mag;
    logic        [DATA_W:0]   div_shift;
    logic        [DATA_W+1:0] div_trial;

    // Result and output registers.
    clamp_t                   out_clamp;
    clamp_t                   integ_clamp;
    logic signed [SUM_W-1:0]  total;
    logic signed [DATA_W-1:0] res_drive_reg;
    logic                     res_clamped_reg;
    logic                     res_zero_reg;
    logic signed [DATA_W-1:0] out_drive_reg;
    logic                     out_clamped_reg;
    logic                     out_zero_reg;

    // Configuration writes; indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= '0;
            limit_high_reg <= LIMIT_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_data;
                REG_GAIN_I:     gain_i_reg     <= cfg_data;
                REG_GAIN_D:     gain_d_reg     <= cfg_data;
                REG_LIMIT_LOW:  limit_low_reg  <= cfg_data;
                REG_LIMIT_HIGH: limit_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Error of the incoming word, saturated.
    assign err_next = sat_sum(SUM_W'(target) - SUM_W'(measurement));

    // Multiplier operand selection; elapsed is unsigned.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_P:
            begin
                opa = OPND_W'(gain_p_reg);
                opb = OPND_W'(err_reg);
            end
            MSEL_I:
            begin
                opa = OPND_W'(gain_i_reg);
                opb = OPND_W'(err_reg);
            end
            MSEL_D:
            begin
                opa = OPND_W'(gain_d_reg);
                opb = OPND_W'(diff_reg);
            end
            MSEL_INC:
            begin
                opa = OPND_W'(a_reg);
                opb = {1'b0, dt_reg};
            end
            default:
            begin
                opa = OPND_W'(gain_p_reg);
                opb = OPND_W'(err_reg);
            end
        endcase
    end

    assign prod_next = opa * opb;

    // Integral update: saturating add, then clamp to the limits.
    assign integ_clamp   = clamp_lim(SUM_W'(sat_sum(SUM_W'(integral_reg) + SUM_W'(inc_reg))),
                                     limit_low_reg, limit_high_reg);
    assign integral_next = integ_clamp.val;

    // Divider: magnitude of the numerator and one restoring step.
    assign num_mag   = num_reg[DATA_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign div_shift = {div_rem_reg, div_quo_reg[DIVD_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dt_reg};

    // Sign fix and saturation of the quotient, truncated towards zero.
    always_comb
    begin
        if (zero_reg)
            d_next = '0;
        else if (!div_neg_reg)
        begin
            if (div_quo_reg[DIVD_W-1:DATA_W-1] != '0)
                d_next = SAT_MAX;
            else
                d_next = div_quo_reg[DATA_W-1:0];
        end
        else
        begin
            if (div_quo_reg[DIVD_W-1:DATA_W] != '0 ||
                (div_quo_reg[DATA_W-1] && div_quo_reg[DATA_W-2:0] != '0))
                d_next = SAT_MIN;
            else
                d_next = ~div_quo_reg[DATA_W-1:0] + 1'b1;
        end
    end

    // Output sum and its exact clamp.
    assign total     = SUM_W'(p_reg) + SUM_W'(integral_reg) + SUM_W'(d_reg);
    assign out_clamp = clamp_lim(total, limit_low_reg, limit_high_reg);

    assign stat.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Kept state and divider count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
                integral_reg <= '0;
            else if (cmd.integ_upd)
                integral_reg <= integral_next;
            if (cmd.integ_upd)
                prev_reg <= err_reg;
            if (cmd.div_load)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.take)
        begin
            err_reg  <= err_next;
            dt_reg   <= elapsed;
            zero_reg <= (elapsed == '0);
        end
        if (cmd.cap_diff)
            diff_reg <= sat_sum(SUM_W'(err_reg) - SUM_W'(prev_reg));
        if (cmd.cap_p)
            p_reg <= sat_q(prod_reg);
        if (cmd.cap_a)
            a_reg <= sat_q(prod_reg);
        if (cmd.cap_num)
            num_reg <= sat_q(prod_reg);
        if (cmd.cap_inc)
            inc_reg <= sat_q(prod_reg);
        if (cmd.div_load)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= {num_mag, {FRAC_W{1'b0}}};
            div_neg_reg <= num_reg[DATA_W-1];
        end
        else if (cmd.div_step)
        begin
            if (!div_trial[DATA_W+1])
            begin
                div_rem_reg <= div_trial[DATA_W-1:0];
                div_quo_reg <= {div_quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_shift[DATA_W-1:0];
                div_quo_reg <= {div_quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
        if (cmd.fix_d)
            d_reg <= d_next;
        if (cmd.clear)
        begin
            res_drive_reg   <= '0;
            res_clamped_reg <= 1'b0;
            res_zero_reg    <= 1'b0;
        end
        else if (cmd.sum)
        begin
            res_drive_reg   <= out_clamp.val;
            res_clamped_reg <= out_clamp.hit;
            res_zero_reg    <= zero_reg;
        end
        if (cmd.out_load)
        begin
            out_drive_reg   <= res_drive_reg;
            out_clamped_reg <= res_clamped_reg;
            out_zero_reg    <= res_zero_reg;
        end
    end

    assign drive        = out_drive_reg;
    assign clamped      = out_clamped_reg;
    assign zero_elapsed = out_zero_reg;

    // With ordered limits the stored integral stays inside them.
    a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.integ_upd) && !$past(cfg_we) && limit_low_reg <= limit_high_reg
        |-> integral_reg >= limit_low_reg && integral_reg <= limit_high_reg)
        else $error("integral outside limits after update");

    // A clamped result equals one of the limits.
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.sum) && !$past(cfg_we) && res_clamped_reg
        |-> res_drive_reg == limit_low_reg || res_drive_reg == limit_high_reg)
        else $error("clamped result is not a limit");

    // Zero elapsed time forces the derivative term to zero.
    a_zero_deriv: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.fix_d) && zero_reg |-> d_reg == '0)
        else $error("derivative not zero for zero elapsed time");

endmodule

### sv/pid_controller_clamped_integral_core.sv
// ----------------------------------------------------------------------------
// PID controller with clamped integral
// Top level: joins the sequencer and the datapath to the item and result
// channels and the configuration write port.
// ----------------------------------------------------------------------------
// Each compute word (kind 0) yields one result, and the next word is taken
// in the cycle after the result is loaded into the output register. The
// restoring divider of the derivative term produces one quotient bit per
// cycle; the four Q16.16 products share one 33x33 multiplier, one product
// per cycle. A clear word (kind 1) zeroes the integral, keeps the last error
// and returns a zero result. A finished result waits in the output register
// while the next word is accepted. Configuration registers may be written
// whenever no word is in flight; writes to indexes beyond the limit
// registers are ignored.
module pid_controller_clamped_integral_core
    import pidc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    pidc_in_if.sink               item,
    pidc_out_if.source            result
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    pidc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_kind    (item.kind),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Arithmetic and state.
    pidc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .measurement  (item.measurement),
        .target       (item.target),
        .elapsed      (item.elapsed),
        .cmd          (cmd),
        .stat         (stat),
        .drive        (result.drive),
        .clamped      (result.clamped),
        .zero_elapsed (result.zero_elapsed)
    );

endmodule

### verif/tb_pid_controller_clamped_integral_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the clamped-integral PID controller core
// Drives compute and clear words through the item channel and works out
// every controller output in Q16.16 with its own copy of the gains, limits,
// integral and last error. Outputs are checked in order against that
// prediction. The run steps through several gain and limit settings,
// including crossed and equal limits, with random gaps on both channels and
// one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_integral_core;
    import pidc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int ONE_Q         = 1 << FRAC_W;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_WORDS  = 1900;
    localparam int PHASES        = 12;
    localparam int STEADY_PHASE  = 3;
    localparam int SQUEEZE_PHASE = 6;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Indexes past the limit registers, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum int {LIM_DEFAULT, LIM_FULL, LIM_WINDOW, LIM_CROSSED, LIM_EQUAL} lim_mode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
        logic                     zero_elapsed;
    } pid_out_t;

    // ------------------------------------------------------------------------
    // Controller predictor and store of expected outputs
    // ------------------------------------------------------------------------
    class pid_scoreboard;
        logic signed [DATA_W-1:0] gain_p, gain_i, gain_d, lim_low, lim_high;
        logic signed [DATA_W-1:0] integ, last_err;
        pid_out_t                 expected_q[$];
        int unsigned              bad;

        function new();
            gain_p   = '0;
            gain_i   = '0;
            gain_d   = '0;
            lim_low  = '0;
            lim_high = LIMIT_HIGH_RESET;
            integ    = '0;
            last_err = '0;
            bad      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_GAIN_P:     gain_p   = val;
                REG_GAIN_I:     gain_i   = val;
                REG_GAIN_D:     gain_d   = val;
                REG_LIMIT_LOW:  lim_low  = val;
                REG_LIMIT_HIGH: lim_high = val;
                default: ;
            endcase
        endfunction

        function longint sat_word(longint x);
            if (x > longint'(SAT_MAX))
                return longint'(SAT_MAX);
            if (x < longint'(SAT_MIN))
                return longint'(SAT_MIN);
            return x;
        endfunction

        // Q16.16 product, floored, then saturated.
        function longint q_mul(longint a, longint b);
            return sat_word((a * b) >>> FRAC_W);
        endfunction

        // The lower limit is tested first, so crossed limits give one of them.
        function longint bound(input longint x, output bit hit);
            hit = 1'b0;
            if (x < longint'(lim_low))
            begin
                hit = 1'b1;
                return longint'(lim_low);
            end
            if (x > longint'(lim_high))
            begin
                hit = 1'b1;
                return longint'(lim_high);
            end
            return x;
        endfunction

        // Work out the output of one accepted word and queue it.
        function void note_word(logic kind, logic signed [DATA_W-1:0] meas,
                                logic signed [DATA_W-1:0] tgt, logic [DATA_W-1:0] el);
            longint   err, p, inc, acc, diff, num, d, sum, dt;
            bit       hit, integ_hit;
            pid_out_t r;
            r = '0;
            if (kind == KIND_CLEAR)
            begin
                integ = '0;
            end
            else
            begin
                dt  = longint'(el);
                err = sat_word(longint'(tgt) - longint'(meas));
                p   = q_mul(gain_p, err);
                inc = q_mul(q_mul(gain_i, err), dt);
                acc = bound(sat_word(longint'(integ) + inc), integ_hit);
                integ = acc[DATA_W-1:0];
                if (dt == 0)
                    d = 0;
                else
                begin
                    diff = sat_word(err - longint'(last_err));
                    num  = q_mul(gain_d, diff);
                    d    = sat_word((num * ONE_Q) / dt);
                end
                sum = bound(p + acc + d, hit);
                last_err       = err[DATA_W-1:0];
                r.drive        = sum[DATA_W-1:0];
                r.clamped      = hit;
                r.zero_elapsed = (dt == 0);
            end
            expected_q.push_back(r);
        endfunction

        // Compare one accepted output word with the oldest expectation.
        function void check_result(pid_out_t got);
            pid_out_t want;
            if (expected_q.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display("%0t: output word with none expected: drive %0d", $realtime,
                             got.drive);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.drive !== want.drive || got.clamped !== want.clamped ||
                    got.zero_elapsed !== want.zero_elapsed)
                begin
                    bad++;
                    if (bad <= 10)
                        $display({"%0t: mismatch drive %0d/%0d clamped %0b/%0b ",
                                  "zero_elapsed %0b/%0b (expected/actual)"},
                                 $realtime, want.drive, got.drive, want.clamped, got.clamped,
                                 want.zero_elapsed, got.zero_elapsed);
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and block
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    pidc_in_if  item_ch ();
    pidc_out_if result_ch ();

    pid_controller_clamped_integral_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    pid_scoreboard        sb;
    bit                   steady;
    int                   hold_requests;
    logic [CFG_IDX_W-1:0] spare_idx;
    int unsigned          words_sent;
    int unsigned          clears_sent;
    int unsigned          zero_dt_sent;
    int unsigned          settings_used;

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < 19)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Check every output word taken by the result side.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(pid_out_t'{result_ch.drive, result_ch.clamped,
                                       result_ch.zero_elapsed});
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Load all five registers, plus one ignored index in rotation.
    task automatic set_all(input logic signed [DATA_W-1:0] kp, input logic signed [DATA_W-1:0] ki,
                           input logic signed [DATA_W-1:0] kd, input logic signed [DATA_W-1:0] lo,
                           input logic signed [DATA_W-1:0] hi);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(spare_idx, $urandom);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_LIMIT_LOW, lo);
        write_reg(REG_LIMIT_HIGH, hi);
        cfg_we <= 1'b0;
        spare_idx = (spare_idx == REG_SPARE_LAST) ? REG_SPARE_FIRST : spare_idx + 1'b1;
        settings_used++;
    endtask

    // Offer one word, maybe after a gap, and note it once it is taken.
    task automatic send_word(input logic kind, input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] tgt, input logic [DATA_W-1:0] el);
        if (!steady && $urandom_range(99) < 19)
        begin
            item_ch.valid <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 3))
                @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.measurement <= meas;
        item_ch.target      <= tgt;
        item_ch.elapsed     <= el;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_word(kind, meas, tgt, el);
        words_sent++;
        if (kind == KIND_CLEAR)
            clears_sent++;
        else if (el == '0)
            zero_dt_sent++;
    endtask

    // Let every outstanding output arrive so the block is idle.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random field values, weighted towards realistic control values
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] rand_gain();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
        if (r < 80)
            return $urandom;
        case ($urandom_range(3))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            default: return ONE_Q;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return int'($urandom_range(0, 400 * ONE_Q)) - 200 * ONE_Q;
        if (r < 85)
            return $urandom;
        case ($urandom_range(3))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_elapsed();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 60)
            return $urandom_range(1, 2 * ONE_Q);
        if (r < 72)
            return $urandom_range(1, 16);
        if (r < 86)
            return $urandom;
        case ($urandom_range(2))
            0:       return '1;
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            default: return ONE_Q;
        endcase
    endfunction

    // One random setting; the limit shape is chosen by the phase.
    task automatic random_setting(input lim_mode_t mode);
        logic signed [DATA_W-1:0] lo, hi;
        case (mode)
            LIM_DEFAULT:
            begin
                lo = '0;
                hi = LIMIT_HIGH_RESET;
            end
            LIM_FULL:
            begin
                lo = SAT_MIN;
                hi = SAT_MAX;
            end
            LIM_WINDOW:
            begin
                lo = -int'($urandom_range(0, 1000 * ONE_Q));
                hi = $urandom_range(0, 1000 * ONE_Q);
            end
            LIM_CROSSED:
            begin
                lo = $urandom_range(1, 100 * ONE_Q);
                hi = -int'($urandom_range(0, 100 * ONE_Q));
            end
            default:
            begin
                lo = rand_value();
                hi = lo;
            end
        endcase
        set_all(rand_gain(), rand_gain(), rand_gain(), lo, hi);
    endtask

    // Half the measurements lie near the set point, the rest at random, some wide and extreme.
    task automatic random_word();
        logic signed [DATA_W-1:0] meas, tgt;
        meas = rand_value();
        if ($urandom_range(1))
            tgt = meas + int'($urandom_range(0, 20 * ONE_Q)) - 10 * ONE_Q;
        else
            tgt = rand_value();
        if ($urandom_range(99) < 6)
            send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
        else
            send_word(KIND_STEP, meas, tgt, rand_elapsed());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb            = new();
        steady        = 1'b0;
        hold_requests = 0;
        spare_idx     = REG_SPARE_FIRST;
        words_sent    = 0;
        clears_sent   = 0;
        zero_dt_sent  = 0;
        settings_used = 0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_STEP;
        item_ch.measurement <= '0;
        item_ch.target      <= '0;
        item_ch.elapsed     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers as left by reset: zero gains give a zero output.
        send_word(KIND_STEP, '0, 10 * ONE_Q, ONE_Q);
        send_word(KIND_STEP, 3 * ONE_Q, '0, '0);
        settle();

        // Unity gains with a symmetric window: saturated error, extreme
        // time steps, zero time step and clears.
        set_all(ONE_Q, ONE_Q, ONE_Q, -100 * ONE_Q, 100 * ONE_Q);
        send_word(KIND_STEP, '0, 5 * ONE_Q, ONE_Q / 10);
        send_word(KIND_STEP, '0, 5 * ONE_Q, '0);
        send_word(KIND_CLEAR, '0, '0, '0);
        send_word(KIND_STEP, SAT_MIN, SAT_MAX, ONE_Q);
        send_word(KIND_STEP, SAT_MAX, SAT_MIN, ONE_Q);
        send_word(KIND_STEP, 2 * ONE_Q, -3 * ONE_Q, '1);
        send_word(KIND_STEP, -7 * ONE_Q, 4 * ONE_Q, 32'd1);
        send_word(KIND_CLEAR, '1, '1, '1);
        send_word(KIND_STEP, ONE_Q, '0, '0);
        settle();

        // Extreme gains with limits over the whole range.
        set_all(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX);
        send_word(KIND_STEP, 32'sd1, '0, 32'd1);
        send_word(KIND_STEP, SAT_MIN, SAT_MAX, '1);
        send_word(KIND_STEP, '1, '1, '0);
        send_word(KIND_STEP, SAT_MAX, SAT_MIN, 32'd1);
        settle();

        // Crossed limits: every output is one of the two bounds.
        set_all(ONE_Q / 2, 2 * ONE_Q, -ONE_Q, 10 * ONE_Q, -10 * ONE_Q);
        send_word(KIND_STEP, '0, '0, ONE_Q);
        send_word(KIND_STEP, 3 * ONE_Q, 20 * ONE_Q, ONE_Q / 2);
        send_word(KIND_STEP, 20 * ONE_Q, -50 * ONE_Q, '0);
        settle();

        // Equal limits.
        set_all(-3 * ONE_Q / 2, ONE_Q / 4, '0, 5 * ONE_Q, 5 * ONE_Q);
        send_word(KIND_STEP, ONE_Q, -ONE_Q, ONE_Q);
        send_word(KIND_STEP, -ONE_Q, ONE_Q, ONE_Q / 1000);
        send_word(KIND_CLEAR, '0, '0, '0);
        settle();

        // Random phases, each under a fresh setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_setting(lim_mode_t'(ph % 5));
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                // Hold the result side off and keep offering words back to
                // back, so the block fills and stops taking input.
                if (ph == SQUEEZE_PHASE && n == 40)
                begin
                    hold_requests++;
                    steady = 1'b1;
                end
                if (ph == SQUEEZE_PHASE && n == 48)
                    steady = 1'b0;
                random_word();
            end
            steady = 1'b0;
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0d expected output words never arrived", sb.outstanding());
            sb.bad += sb.outstanding();
        end
        $display("Sent %0d words: %0d clears and %0d steps with zero elapsed time.",
                 words_sent, clears_sent, zero_dt_sent);
        $display("Used %0d register settings; %0d output words were wrong or unexpected.",
                 settings_used, sb.bad);
        if (sb.bad == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### pid_controller_clamped_integral_core.f
sv/pidc_pkg.sv
sv/pidc_in_if.sv
sv/pidc_out_if.sv
sv/pidc_ctrl.sv
sv/pidc_dp.sv
sv/pid_controller_clamped_integral_core.sv
verif/tb_pid_controller_clamped_integral_core.sv
